>>> rtl/text_console_char_writer_unit_assert.svh
// Assertion macros shared by the console checker.
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication under the clock and the active-low reset.
`define CCW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console check failed: same-cycle implication");

// Next-cycle implication under the clock and the active-low reset.
`define CCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console check failed: next-cycle implication");

`endif

>>> rtl/ccw_pkg.sv
// Shared constants and request codes of the text console character writer.
package ccw_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    localparam int REQ_W      = 3;
    localparam int CHAR_W     = 8;
    localparam int ROW_IN_W   = 5;
    localparam int COL_IN_W   = 7;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_LIN_W  = 11;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    localparam logic [REQ_W-1:0] REQ_PUT        = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET_CURSOR = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PUT_STAY   = 3'd4;

    localparam logic [CHAR_W-1:0] NL_CODE    = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [CELL_W-1:0] POWER_ON_BLANK = 16'h0720;

endpackage

>>> rtl/ccw_cell_mem.sv
// Character cell store: one write port and one registered read port.
module ccw_cell_mem #(
    parameter int DEPTH = ccw_pkg::DEFAULT_COLUMNS * ccw_pkg::DEFAULT_ROWS,
    localparam int MAW = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [MAW-1:0]              waddr,
    input  logic [ccw_pkg::CELL_W-1:0]  wdata,
    input  logic                        re,
    input  logic [MAW-1:0]              raddr,
    output logic [ccw_pkg::CELL_W-1:0]  rdata
);
    import ccw_pkg::*;

    logic [CELL_W-1:0] cells [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cells[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= cells[raddr];
        end
    end

endmodule

>>> rtl/ccw_lin_unit.sv
// Shared linear-position unit: registers row * COLUMNS + column.
module ccw_lin_unit #(
    parameter int COLUMNS = ccw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = ccw_pkg::DEFAULT_ROWS,
    localparam int CW = $clog2(COLUMNS + 1),
    localparam int RW = $clog2(ROWS),
    localparam int AW = $clog2(ROWS * COLUMNS + 1)
) (
    input  logic          clk,
    input  logic          en,
    input  logic [RW-1:0] row,
    input  logic [CW-1:0] col,
    output logic [AW-1:0] lin
);
    import ccw_pkg::*;

    logic [AW-1:0] lin_reg;
    logic [AW-1:0] lin_next;

    // Constant multiplier followed by one add; result is held until the next use.
    assign lin_next = AW'(32'(row) * COLUMNS + 32'(col));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg <= lin_next;
        end
    end

    assign lin = lin_reg;

endmodule

>>> rtl/text_console_char_writer_unit.sv
// Top level of the text console character writer: sequencer, cursor and stream ports.
// Set cursor and a newline put pass through the cursor-position step and the result step;
// put and read first work out the cell address and access the cell. A scrolling put adds
// a row copy then blanking of the last row; a clear adds blanking of every cell.
// One request is in work at a time; the single cell-store write port and the shared
// position unit set this. Reset (rst_n low, asynchronous) homes the cursor, sets the
// attribute to 7 and then sweeps every cell of the store to 0x0720 before s_tready rises.
module text_console_char_writer_unit #(
    parameter int COLUMNS = ccw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = ccw_pkg::DEFAULT_ROWS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: char_code [7:0], row [12:8], column [19:13], zero pad [23:20]
    input  logic [ccw_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type [2:0]
    input  logic [ccw_pkg::REQ_W-1:0]      s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: cursor_column [6:0], cursor_row [11:7], cursor_linear [22:12],
    //          cell_data [38:23], scrolled [39]
    output logic [ccw_pkg::M_TDATA_W-1:0]  m_tdata,
    // Attribute register write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ccw_pkg::ATTR_W-1:0]     cfg_data
);
    import ccw_pkg::*;

    localparam int NCELLS = ROWS * COLUMNS;
    localparam int CW     = $clog2(COLUMNS + 1);
    localparam int RW     = $clog2(ROWS);
    localparam int AW     = $clog2(NCELLS + 1);
    localparam int MAW    = $clog2(NCELLS);

    localparam logic [MAW-1:0] LAST_CELL   = MAW'(NCELLS - 1);
    localparam logic [MAW-1:0] COPY_END    = MAW'(NCELLS - COLUMNS);
    localparam logic [MAW-1:0] ROW_STRIDE  = MAW'(COLUMNS);
    localparam logic [RW-1:0]  BOTTOM_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0]  WRAP_COL    = CW'(COLUMNS);
    localparam logic [CW-1:0]  RIGHT_COL   = CW'(COLUMNS - 1);
    localparam logic [AW-1:0]  CELL_LIMIT  = AW'(NCELLS);

    // Sequencer states.
    localparam logic [3:0] S_INIT   = 4'd0;  // power-on sweep of the store
    localparam logic [3:0] S_IDLE   = 4'd1;  // waiting for a request
    localparam logic [3:0] S_ADDR   = 4'd2;  // position unit works out the cell address
    localparam logic [3:0] S_ACC    = 4'd3;  // cell write or read issue
    localparam logic [3:0] S_LIN    = 4'd4;  // position unit works out the cursor position
    localparam logic [3:0] S_FIN    = 4'd5;  // result into the output register
    localparam logic [3:0] S_SCROLL = 4'd6;  // copy every row up by one
    localparam logic [3:0] S_BLANK  = 4'd7;  // blank the last row
    localparam logic [3:0] S_CLEAR  = 4'd8;  // blank every cell

    logic [3:0]         state_reg, state_next;
    logic [MAW-1:0]     sweep_reg, sweep_next;
    logic               pend_reg, pend_next;
    logic [REQ_W-1:0]   req_reg, req_next;
    logic [CHAR_W-1:0]  ch_reg, ch_next;
    logic [RW-1:0]      rsat_reg, rsat_next;
    logic [CW-1:0]      csat_reg, csat_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic               scrolled_reg, scrolled_next;
    logic [CELL_W-1:0]  data_reg, data_next;
    logic [ATTR_W-1:0]  attr_reg;
    logic               out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    // Request fields as they arrive.
    logic [REQ_W-1:0]    in_req;
    logic [CHAR_W-1:0]   in_ch;
    logic [ROW_IN_W-1:0] in_row;
    logic [COL_IN_W-1:0] in_col;
    logic [RW-1:0]       in_row_sat;
    logic [CW-1:0]       in_col_sat;

    // Cursor after the newline, wrap and scroll steps of a put.
    logic                put_adv;
    logic                put_scroll;
    logic [RW-1:0]       put_row;
    logic [CW-1:0]       put_col;
    logic                put_nl;

    logic                accept;
    logic                out_free;
    logic                is_put;

    // Position unit and store connections.
    logic                lin_en;
    logic [RW-1:0]       lin_row;
    logic [CW-1:0]       lin_col;
    logic [AW-1:0]       lin_q;
    logic                lin_in_range;

    logic                mem_we;
    logic [MAW-1:0]      mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [MAW-1:0]      mem_raddr;
    logic [CELL_W-1:0]   mem_rdata;

    assign in_req = s_tuser;
    assign in_ch  = s_tdata[7:0];
    assign in_row = s_tdata[12:8];
    assign in_col = s_tdata[19:13];

    // Out-of-range positions saturate to the last row and the last column.
    assign in_row_sat = (32'(in_row) > ROWS - 1) ? BOTTOM_ROW : RW'(in_row);
    assign in_col_sat = (32'(in_col) > COLUMNS - 1) ? RIGHT_COL : CW'(in_col);

    // A newline or a pending wrap moves to the start of the next row; passing the
    // bottom row scrolls instead and leaves the cursor on the bottom row.
    assign put_nl     = (in_ch == NL_CODE);
    assign put_adv    = put_nl || (col_reg == WRAP_COL);
    assign put_scroll = put_adv && (row_reg == BOTTOM_ROW);
    assign put_row    = put_scroll ? BOTTOM_ROW : (row_reg + RW'(put_adv));
    assign put_col    = put_adv ? '0 : col_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign is_put    = (req_reg == REQ_PUT) || (req_reg == REQ_PUT_STAY);
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The position unit serves both the cell address and the reported cursor.
    assign lin_en  = (state_reg == S_ADDR) || (state_reg == S_LIN);
    assign lin_row = ((state_reg == S_ADDR) && (req_reg == REQ_READ)) ? rsat_reg : row_reg;
    assign lin_col = ((state_reg == S_ADDR) && (req_reg == REQ_READ)) ? csat_reg : col_reg;
    assign lin_in_range = (lin_q < CELL_LIMIT);

    ccw_lin_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_lin (
        .clk (clk),
        .en  (lin_en),
        .row (lin_row),
        .col (lin_col),
        .lin (lin_q)
    );

    // Store port selection. During the row copy a cell read one row further on is
    // written back in the next cycle, once its registered read data has arrived.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = {attr_reg, SPACE_CODE};
        mem_re    = 1'b0;
        mem_raddr = sweep_reg + ROW_STRIDE;
        unique case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = POWER_ON_BLANK;
            end
            S_SCROLL:
            begin
                mem_we    = pend_reg;
                mem_waddr = sweep_reg - MAW'(1);
                mem_wdata = mem_rdata;
                mem_re    = (sweep_reg != COPY_END);
            end
            S_BLANK, S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_ACC:
            begin
                mem_we    = is_put && lin_in_range;
                mem_waddr = lin_q[MAW-1:0];
                mem_wdata = {attr_reg, ch_reg};
                mem_re    = (req_reg == REQ_READ);
                mem_raddr = lin_q[MAW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    ccw_cell_mem #(
        .DEPTH (NCELLS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        pend_next     = pend_reg;
        req_next      = req_reg;
        ch_next       = ch_reg;
        rsat_next     = rsat_reg;
        csat_next     = csat_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        scrolled_next = scrolled_reg;
        data_next     = data_reg;
        unique case (state_reg)
            S_INIT:
            begin
                sweep_next = sweep_reg + MAW'(1);
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next      = in_req;
                    ch_next       = in_ch;
                    rsat_next     = in_row_sat;
                    csat_next     = in_col_sat;
                    scrolled_next = 1'b0;
                    data_next     = '0;
                    sweep_next    = '0;
                    pend_next     = 1'b0;
                    unique case (in_req)
                        REQ_PUT:
                        begin
                            row_next      = put_row;
                            col_next      = put_col;
                            scrolled_next = put_scroll;
                            if (put_scroll)
                            begin
                                state_next = S_SCROLL;
                            end
                            else if (put_nl)
                            begin
                                state_next = S_LIN;
                            end
                            else
                            begin
                                state_next = S_ADDR;
                            end
                        end
                        REQ_SET_CURSOR:
                        begin
                            row_next   = in_row_sat;
                            col_next   = in_col_sat;
                            state_next = S_LIN;
                        end
                        REQ_READ, REQ_PUT_STAY:
                        begin
                            state_next = S_ADDR;
                        end
                        REQ_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_LIN;
                        end
                    endcase
                end
            end
            S_ADDR:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (req_reg == REQ_PUT)
                begin
                    col_next = col_reg + CW'(1);
                end
                state_next = S_LIN;
            end
            S_LIN:
            begin
                if (req_reg == REQ_READ)
                begin
                    data_next = mem_rdata;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCROLL:
            begin
                if (sweep_reg == COPY_END)
                begin
                    pend_next  = 1'b0;
                    state_next = S_BLANK;
                end
                else
                begin
                    pend_next  = 1'b1;
                    sweep_next = sweep_reg + MAW'(1);
                end
            end
            S_BLANK:
            begin
                sweep_next = sweep_reg + MAW'(1);
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = (ch_reg == NL_CODE) ? S_LIN : S_ADDR;
                end
            end
            S_CLEAR:
            begin
                sweep_next = sweep_reg + MAW'(1);
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = S_LIN;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            sweep_reg <= '0;
            pend_reg  <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
            attr_reg  <= ATTR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            pend_reg  <= pend_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    // Request payload needs no reset.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        ch_reg       <= ch_next;
        rsat_reg     <= rsat_next;
        csat_reg     <= csat_next;
        scrolled_reg <= scrolled_next;
        data_reg     <= data_next;
    end

    // Output register: the result waits here until the transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == S_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FIN) && out_free)
        begin
            out_data_reg <= {scrolled_reg, data_reg, OUT_LIN_W'(lin_q),
                             OUT_ROW_W'(row_reg), OUT_COL_W'(col_reg)};
        end
    end

endmodule

>>> rtl/ccw_checker.sv
// Port-level checker of the text console character writer, bound to the top level.
`include "text_console_char_writer_unit_assert.svh"

module ccw_checker #(
    parameter int COLUMNS = ccw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = ccw_pkg::DEFAULT_ROWS
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ccw_pkg::M_TDATA_W-1:0] m_tdata
);
    import ccw_pkg::*;

    // The linear position only matches the packed fields while none of them is truncated.
    localparam bit LIN_CHECK = (ROWS <= 32) && (COLUMNS < 128) && (ROWS * COLUMNS < 2048);

    logic [OUT_LIN_W-1:0] lin_expect;
    logic [OUT_ROW_W-1:0] bottom_row;

    assign lin_expect = OUT_LIN_W'(32'(m_tdata[11:7]) * COLUMNS + 32'(m_tdata[6:0]));
    assign bottom_row = OUT_ROW_W'(ROWS - 1);

    `CCW_ASSERT_NEXT(a_result_held, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    `CCW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

    `CCW_ASSERT_SAME(a_linear_matches, clk, rst_n, m_tvalid, !LIN_CHECK || (m_tdata[22:12] == lin_expect))

    `CCW_ASSERT_SAME(a_scroll_on_bottom, clk, rst_n, m_tvalid && m_tdata[39], (m_tdata[11:7] == bottom_row) && (m_tdata[38:23] == '0))

endmodule

bind text_console_char_writer_unit ccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_ccw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/text_console_char_writer_checker.sv
// Checker that predicts the console's cursor reports and compares them with the result stream.
module text_console_char_writer_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ccw_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [ccw_pkg::REQ_W-1:0]      s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ccw_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ccw_pkg::ATTR_W-1:0]     cfg_data,
    output int                             reports_seen,
    output int                             fault_count
);
    import ccw_pkg::*;

    localparam int COLUMNS      = DEFAULT_COLUMNS;
    localparam int ROWS         = DEFAULT_ROWS;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int REPORT_LIMIT = 10;

    // Same layout as m_tdata, lowest field last.
    typedef struct packed {
        logic                  scrolled;
        logic [CELL_W-1:0]     cell_word;
        logic [OUT_LIN_W-1:0]  linear;
        logic [OUT_ROW_W-1:0]  row;
        logic [OUT_COL_W-1:0]  col;
    } cursor_report_t;

    logic [CELL_W-1:0] screen [CELLS];
    logic [ATTR_W-1:0] attribute;
    int                cursor_col;
    int                cursor_row;
    int                errors;
    cursor_report_t    pending_reports [$];

    // Applies one request to the shadow screen and cursor and returns the report it yields.
    function automatic cursor_report_t apply_request(input logic [REQ_W-1:0]    kind,
                                                     input logic [CHAR_W-1:0]   ch,
                                                     input logic [ROW_IN_W-1:0] r,
                                                     input logic [COL_IN_W-1:0] c);
        cursor_report_t rep;
        int             pos;
        int             clamp_row;
        int             clamp_col;
        rep = '0;
        clamp_row = (int'(r) > ROWS - 1) ? ROWS - 1 : int'(r);
        clamp_col = (int'(c) > COLUMNS - 1) ? COLUMNS - 1 : int'(c);
        case (kind)
            REQ_PUT:
            begin
                if (ch == NL_CODE)
                begin
                    cursor_col = 0;
                    cursor_row++;
                end
                if (cursor_col >= COLUMNS)
                begin
                    cursor_col = 0;
                    cursor_row++;
                end
                if (cursor_row >= ROWS)
                begin
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen[i] = screen[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen[i] = {attribute, SPACE_CODE};
                    cursor_row   = ROWS - 1;
                    rep.scrolled = 1'b1;
                end
                if (ch != NL_CODE)
                begin
                    screen[cursor_row * COLUMNS + cursor_col] = {attribute, ch};
                    cursor_col++;
                end
            end
            REQ_SET_CURSOR:
            begin
                cursor_row = clamp_row;
                cursor_col = clamp_col;
            end
            REQ_READ:
                rep.cell_word = screen[clamp_row * COLUMNS + clamp_col];
            REQ_CLEAR:
                for (int i = 0; i < CELLS; i++)
                    screen[i] = {attribute, SPACE_CODE};
            REQ_PUT_STAY:
            begin
                // With a wrap pending this lands on column 0 of the next row, or nowhere.
                pos = cursor_row * COLUMNS + cursor_col;
                if (pos < CELLS)
                    screen[pos] = {attribute, ch};
            end
            default:
                ;
        endcase
        rep.col    = OUT_COL_W'(cursor_col);
        rep.row    = OUT_ROW_W'(cursor_row);
        rep.linear = OUT_LIN_W'(cursor_row * COLUMNS + cursor_col);
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cursor_report_t want;
        cursor_report_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = POWER_ON_BLANK;
            attribute  = ATTR_RESET;
            cursor_col = 0;
            cursor_row = 0;
            errors     = 0;
            pending_reports.delete();
            reports_seen <= 0;
            fault_count  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = cursor_report_t'(m_tdata);
                reports_seen <= reports_seen + 1;
                if (pending_reports.size() == 0)
                begin
                    if (errors < REPORT_LIMIT)
                        $display("cursor report %0d arrived with nothing expected: %h",
                                 reports_seen, m_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (got.col !== want.col || got.row !== want.row
                        || got.linear !== want.linear || got.cell_word !== want.cell_word
                        || got.scrolled !== want.scrolled)
                    begin
                        if (errors < REPORT_LIMIT)
                        begin
                            $display("report %0d: expected col %0d row %0d lin %0d cell %h scr %b",
                                     reports_seen, want.col, want.row, want.linear,
                                     want.cell_word, want.scrolled);
                            $display("report %0d: got      col %0d row %0d lin %0d cell %h scr %b",
                                     reports_seen, got.col, got.row, got.linear,
                                     got.cell_word, got.scrolled);
                        end
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                attribute = cfg_data;
            if (s_tvalid && s_tready)
                pending_reports.push_back(apply_request(s_tuser, s_tdata[CHAR_W-1:0],
                    s_tdata[CHAR_W +: ROW_IN_W], s_tdata[CHAR_W + ROW_IN_W +: COL_IN_W]));
            // Reports still owed count as faults, so the verdict catches any left over.
            fault_count <= errors + pending_reports.size();
        end
    end

endmodule

>>> tb/sv/text_console_char_writer_unit_test.sv
// Testbench top for the text console character writer: stimulus, back-pressure and verdict.
module text_console_char_writer_unit_test;
    import ccw_pkg::*;

    localparam int COLUMNS     = DEFAULT_COLUMNS;
    localparam int ROWS        = DEFAULT_ROWS;
    localparam int REQ_CODES   = 1 << REQ_W;
    localparam int MAX_GAP     = 11;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 300;
    // The slowest gap between two transactions is a clear, a scroll or the store sweep
    // after reset; the watchdog allows many times that.
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 40;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [REQ_W-1:0]       s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [ATTR_W-1:0]      cfg_data  = '0;

    int   reports_seen;
    int   fault_count;
    int   requests_sent   = 0;
    int   quiet_cycles    = 0;
    // When set, the corresponding side stops inserting idle cycles for a while.
    bit   sender_steady   = 1'b0;
    bit   receiver_steady = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    text_console_char_writer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    text_console_char_writer_checker console_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .reports_seen (reports_seen),
        .fault_count  (fault_count)
    );

    // Offers one request and returns at the edge where the transaction completes. The valid
    // is left high so that a back-to-back request never drops and raises it in one step;
    // it is lowered only when an idle gap follows.
    task automatic send_request(input logic [REQ_W-1:0]    kind,
                                input logic [CHAR_W-1:0]   ch,
                                input logic [ROW_IN_W-1:0] r,
                                input logic [COL_IN_W-1:0] c);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - CHAR_W - ROW_IN_W - COL_IN_W){1'b0}}, c, r, ch};
        do
            @(posedge clk);
        while (!s_tready);
        requests_sent++;
    endtask

    // Stops offering requests and waits until every report owed has been taken.
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (reports_seen != requests_sent)
            @(posedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic shaped mostly as text: a cursor placement (often on the bottom row or
    // near the right edge, so that wraps and scrolls are common) followed by a run of puts.
    // Reads sample the screen, and single requests of any code add noise.
    task automatic run_random_phase(input int quota);
        int                  done;
        int                  pick;
        int                  burst;
        logic [ROW_IN_W-1:0] r;
        logic [COL_IN_W-1:0] c;
        logic [CHAR_W-1:0]   ch;
        logic [REQ_W-1:0]    kind;
        done = 0;
        while (done < quota)
        begin
            sender_steady = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                r = ($urandom_range(0, 3) == 0) ? ROW_IN_W'(ROWS - 1) : ROW_IN_W'($urandom);
                c = ($urandom_range(0, 2) == 0) ?
                    COL_IN_W'($urandom_range(COLUMNS - 4, COLUMNS - 1)) : COL_IN_W'($urandom);
                send_request(REQ_SET_CURSOR, CHAR_W'($urandom), r, c);
                burst = $urandom_range(1, 24);
                repeat (burst)
                begin
                    ch   = ($urandom_range(0, 7) == 0) ? NL_CODE : CHAR_W'($urandom);
                    kind = ($urandom_range(0, 9) == 0) ? REQ_PUT_STAY : REQ_PUT;
                    send_request(kind, ch, ROW_IN_W'($urandom), COL_IN_W'($urandom));
                end
                done += burst + 1;
            end
            else if (pick < 65)
            begin
                burst = $urandom_range(1, 6);
                repeat (burst)
                    send_request(REQ_READ, CHAR_W'($urandom), ROW_IN_W'($urandom),
                                 COL_IN_W'($urandom));
                done += burst;
            end
            else if (pick < 90)
            begin
                // Any code, unused ones included; clears are kept rare because they are slow.
                kind = REQ_W'($urandom_range(0, REQ_CODES - 1));
                if (kind == REQ_CLEAR)
                    kind = REQ_PUT;
                send_request(kind, CHAR_W'($urandom), ROW_IN_W'($urandom), COL_IN_W'($urandom));
                done++;
            end
            else if (pick < 92)
            begin
                send_request(REQ_CLEAR, CHAR_W'($urandom), ROW_IN_W'($urandom),
                             COL_IN_W'($urandom));
                done++;
            end
            else
            begin
                // Overwrite in place, then put, so the stay-put write is seen being replaced.
                send_request(REQ_PUT_STAY, CHAR_W'($urandom), ROW_IN_W'($urandom),
                             COL_IN_W'($urandom));
                send_request(REQ_PUT, CHAR_W'($urandom), ROW_IN_W'($urandom),
                             COL_IN_W'($urandom));
                done += 2;
            end
        end
    endtask

    // Result side: for every report it holds tready low for a random number of cycles,
    // and now and then switches to a stretch of taking reports without delay.
    initial
    begin
        int gap;
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                receiver_steady = !receiver_steady;
            gap = receiver_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Watchdog: a long run of cycles with no transaction on any channel means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [ATTR_W-1:0] attr;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening with the reset attribute. The first reads must see the power-on
        // blank, and an out-of-range position must clamp to the bottom-right cell.
        send_request(REQ_READ, 8'h00, 5'd0, 7'd0);
        send_request(REQ_READ, 8'hFF, '1, '1);
        // Plain puts, including the top and bottom character codes.
        send_request(REQ_PUT, 8'h41, 5'd0, 7'd0);
        send_request(REQ_PUT, 8'hFF, 5'd0, 7'd0);
        send_request(REQ_PUT, 8'h00, 5'd0, 7'd0);
        send_request(REQ_READ, 8'h00, 5'd0, 7'd1);
        // Cursor placed out of range clamps to the last cell; a put there leaves a wrap
        // pending, a stay-put on the bottom row is then dropped, and the next put scrolls.
        send_request(REQ_SET_CURSOR, 8'h00, '1, '1);
        send_request(REQ_PUT, 8'h78, 5'd0, 7'd0);
        send_request(REQ_PUT_STAY, 8'h79, 5'd0, 7'd0);
        send_request(REQ_PUT, 8'h7A, 5'd0, 7'd0);
        send_request(REQ_READ, 8'h00, 5'd23, 7'd79);
        // A newline on the bottom row scrolls as well.
        send_request(REQ_SET_CURSOR, 8'h00, 5'd24, 7'd5);
        send_request(REQ_PUT, NL_CODE, 5'd0, 7'd0);
        // Wrap pending away from the bottom: stay-put stores the newline code on the next
        // row, and a newline then moves down by just one row.
        send_request(REQ_SET_CURSOR, 8'h00, 5'd3, 7'd79);
        send_request(REQ_PUT, 8'h71, 5'd0, 7'd0);
        send_request(REQ_PUT_STAY, NL_CODE, 5'd0, 7'd0);
        send_request(REQ_READ, 8'h00, 5'd4, 7'd0);
        send_request(REQ_PUT, NL_CODE, 5'd0, 7'd0);
        // Codes beyond the defined requests change nothing.
        for (int k = REQ_PUT_STAY + 1; k < REQ_CODES; k++)
            send_request(REQ_W'(k), 8'hFF, '1, '1);
        send_request(REQ_CLEAR, 8'h00, 5'd0, 7'd0);
        send_request(REQ_READ, 8'h00, 5'd24, 7'd79);
        send_request(REQ_SET_CURSOR, 8'h00, 5'd0, 7'd0);

        // Random phases, each under its own attribute, written only once the block is idle.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_reports();
            case (phase)
                0:       attr = 8'hFF;
                1:       attr = 8'h00;
                2:       attr = 8'hA5;
                3:       attr = 8'h5A;
                4:       attr = ATTR_W'($urandom);
                default: attr = ATTR_RESET;
            endcase
            write_attribute(attr);
            run_random_phase(PHASE_ITEMS);
        end

        drain_reports();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> text_console_char_writer_unit.f
+incdir+rtl
rtl/ccw_pkg.sv
rtl/ccw_cell_mem.sv
rtl/ccw_lin_unit.sv
rtl/text_console_char_writer_unit.sv
rtl/ccw_checker.sv
tb/sv/text_console_char_writer_checker.sv
tb/sv/text_console_char_writer_unit_test.sv
